/* src/vrp_pkg.sv */
package vrp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ANGLE_X       = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y       = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z       = 3'd2;
  localparam logic [2:0] REG_ZOOM          = 3'd3;
  localparam logic [2:0] REG_MODEL_DIVISOR = 3'd4;
  localparam logic [2:0] REG_FOCAL_SHIFT   = 3'd5;
  localparam logic [2:0] REG_CENTRE_X      = 3'd6;
  localparam logic [2:0] REG_CENTRE_Y      = 3'd7;

  // Matrix coefficient width: |m * zoom * 4| stays below 2^19.
  localparam int MW = 21;
  // Vertex products, row sums and rotated coordinates.
  localparam int PW = 37;
  localparam int SW = 39;
  localparam int RW = 31;
  // Perspective divider: signed numerator/denominator and magnitudes.
  localparam int NSW = 49;
  localparam int DSW = 35;
  localparam int NW  = 48;
  localparam int DW  = 34;
  // Quotient bits kept; anything at or above 2^QB saturates the output anyway.
  localparam int QB  = 17;
  localparam int CW  = DW + QB;
  localparam int QW  = QB + 2;
  // Register stages inside the divider.
  localparam int DIV_LAT = QB + 2;

  typedef logic signed [MW-1:0] coef_t;

  typedef struct packed {
    logic [8:0]         angle_x;
    logic [8:0]         angle_y;
    logic [8:0]         angle_z;
    logic [9:0]         zoom;
    logic [14:0]        model_divisor;
    logic signed [15:0] focal_shift;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
  } vrp_cfg_t;

  localparam logic signed [7:0] SINE64 [72] = '{
    8'sd0, 8'sd6, 8'sd11, 8'sd16, 8'sd22, 8'sd27, 8'sd32, 8'sd37, 8'sd41, 8'sd45,
    8'sd49, 8'sd52, 8'sd55, 8'sd58, 8'sd60, 8'sd62, 8'sd63, 8'sd64,
    8'sd64, 8'sd64, 8'sd63, 8'sd62, 8'sd60, 8'sd58, 8'sd55, 8'sd52, 8'sd49, 8'sd45,
    8'sd41, 8'sd37, 8'sd32, 8'sd27, 8'sd22, 8'sd16, 8'sd11, 8'sd6,
    8'sd0, -8'sd6, -8'sd11, -8'sd16, -8'sd22, -8'sd27, -8'sd32, -8'sd37, -8'sd41,
    -8'sd45, -8'sd49, -8'sd52, -8'sd55, -8'sd58, -8'sd60, -8'sd62, -8'sd63, -8'sd64,
    -8'sd64, -8'sd64, -8'sd63, -8'sd62, -8'sd60, -8'sd58, -8'sd55, -8'sd52, -8'sd49,
    -8'sd45, -8'sd41, -8'sd37, -8'sd32, -8'sd27, -8'sd22, -8'sd16, -8'sd11, -8'sd6
  };

  // Table index of an angle: (angle mod 360) / 5, the divide done as *205 >> 10.
  function automatic logic [6:0] angle_index(input logic [8:0] angle);
    logic [8:0]  a;
    logic [16:0] p;
    a = (angle >= 9'd360) ? angle - 9'd360 : angle;
    p = 17'(a) * 17'd205;
    return p[16:10];
  endfunction

  function automatic logic signed [7:0] sine_of(input logic [8:0] angle);
    return SINE64[angle_index(angle)];
  endfunction

  function automatic logic signed [7:0] cosine_of(input logic [8:0] angle);
    logic [6:0] i;
    i = angle_index(angle) + 7'd18;
    if (i >= 7'd72) begin
      i = i - 7'd72;
    end
    return SINE64[i];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -32'sd32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

/* src/vrp_matrix.sv */
module vrp_matrix (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  vrp_pkg::vrp_cfg_t cfg,
  output logic             busy,
  output vrp_pkg::coef_t   coef [9]
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL1  = 6'b000010,
    ST_MUL2  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_NEXT  = 6'b100000
  } mstate_t;

  mstate_t state;
  logic [3:0] idx;
  logic [4:0] bitn;

  logic signed [7:0] sx, cx, sy, cy, sz, cz;
  logic signed [7:0] a1, b1, c1, a2, b2, c2;
  logic sub2;

  logic signed [15:0] p1, p2;
  logic signed [24:0] acc;
  logic signed [8:0]  mval;
  logic signed [21:0] num;
  logic [19:0] rem, quo;
  logic        neg;
  logic [14:0] dv;
  logic [33:0] trial;

  assign sx = vrp_pkg::sine_of(cfg.angle_x);
  assign cx = vrp_pkg::cosine_of(cfg.angle_x);
  assign sy = vrp_pkg::sine_of(cfg.angle_y);
  assign cy = vrp_pkg::cosine_of(cfg.angle_y);
  assign sz = vrp_pkg::sine_of(cfg.angle_z);
  assign cz = vrp_pkg::cosine_of(cfg.angle_z);

  // Every coefficient starts as (a1*b1*c1 +/- a2*b2*c2) >> 12 with floor; the
  // single-product entries use 64 as their third factor.
  always_comb begin
    a1 = sx; b1 = sy; c1 = cz; a2 = cx; b2 = sz; c2 = 8'sd64; sub2 = 1'b0;
    case (idx)
      4'd0: begin a1 = cy; b1 = cz; c1 = 8'sd64; a2 = 8'sd0; end
      4'd1: begin a1 = sx; b1 = sy; c1 = cz; a2 = cx; b2 = sz; sub2 = 1'b1; end
      4'd2: begin a1 = cx; b1 = sy; c1 = cz; a2 = sx; b2 = sz; end
      4'd3: begin a1 = cy; b1 = sz; c1 = 8'sd64; a2 = 8'sd0; end
      4'd4: begin a1 = sx; b1 = sy; c1 = sz; a2 = cx; b2 = cz; end
      4'd5: begin a1 = cx; b1 = sy; c1 = sz; a2 = sx; b2 = cz; sub2 = 1'b1; end
      4'd6: begin a1 = 8'sd0; a2 = sy; b2 = 8'sd64; sub2 = 1'b1; end
      4'd7: begin a1 = sx; b1 = cy; c1 = 8'sd64; a2 = 8'sd0; end
      4'd8: begin a1 = cx; b1 = cy; c1 = 8'sd64; a2 = 8'sd0; end
      default: begin a1 = 8'sd0; a2 = 8'sd0; end
    endcase
  end

  assign mval  = acc[20:12];
  assign num   = 22'(mval) * $signed({1'b0, cfg.zoom, 2'b00});
  assign trial = 34'(dv) << bitn;
  assign busy  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_MUL1;
      idx   <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL1;
            idx   <= 4'd0;
          end
        end
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_SCALE;
        ST_SCALE: state <= ST_DIV;
        ST_DIV: begin
          if (bitn == 5'd0) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (idx == 4'd8) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + 4'd1;
            state <= ST_MUL1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MUL1: begin
        p1 <= 16'(a1) * 16'(b1);
        p2 <= 16'(a2) * 16'(b2);
      end
      ST_MUL2: begin
        if (sub2) begin
          acc <= 25'(p1) * 25'(c1) - 25'(p2) * 25'(c2);
        end else begin
          acc <= 25'(p1) * 25'(c1) + 25'(p2) * 25'(c2);
        end
      end
      ST_SCALE: begin
        neg  <= num[21];
        rem  <= num[21] ? 20'(-num) : 20'(num);
        quo  <= '0;
        bitn <= 5'd19;
        dv   <= (cfg.model_divisor == 15'd0) ? 15'd1 : cfg.model_divisor;
      end
      ST_DIV: begin
        if (34'(rem) >= trial) begin
          rem       <= rem - 20'(trial);
          quo[bitn] <= 1'b1;
        end
        bitn <= bitn - 5'd1;
      end
      ST_NEXT: begin
        coef[idx] <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/vrp_div_pipe.sv */
module vrp_div_pipe (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [vrp_pkg::NSW-1:0]  num,
  input  logic signed [vrp_pkg::DSW-1:0]  den,
  output logic signed [vrp_pkg::QW-1:0]   quo
);

  localparam int NW = vrp_pkg::NW;
  localparam int DW = vrp_pkg::DW;
  localparam int CW = vrp_pkg::CW;
  localparam int QB = vrp_pkg::QB;

  logic [NW-1:0] a_num;
  logic [DW-1:0] a_den;
  logic          a_neg;

  logic [NW-1:0] rem  [QB+1];
  logic [DW-1:0] dd   [QB+1];
  logic [QB-1:0] qq   [QB+1];
  logic          ovf  [QB+1];
  logic          sgn  [QB+1];
  logic [CW-1:0] trial [QB];
  logic          take  [QB];
  logic [QB:0]   mag;

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      trial[j] = CW'(dd[j]) << (QB - 1 - j);
      take[j]  = CW'(rem[j]) >= trial[j];
    end
  end

  // Stage one forms magnitudes; the next flags a quotient of 2^QB or more,
  // then one quotient bit is settled per stage, most significant first.
  always_ff @(posedge clk) begin
    if (en) begin
      a_num <= num[vrp_pkg::NSW-1] ? NW'(-num) : NW'(num);
      a_den <= den[vrp_pkg::DSW-1] ? DW'(-den) : DW'(den);
      a_neg <= num[vrp_pkg::NSW-1] ^ den[vrp_pkg::DSW-1];
      rem[0] <= a_num;
      dd[0]  <= a_den;
      qq[0]  <= '0;
      sgn[0] <= a_neg;
      ovf[0] <= CW'(a_num) >= {a_den, {QB{1'b0}}};
      for (int j = 0; j < QB; j++) begin
        rem[j+1] <= take[j] ? NW'(CW'(rem[j]) - trial[j]) : rem[j];
        qq[j+1]  <= qq[j] | (take[j] ? QB'(1) << (QB - 1 - j) : '0);
        dd[j+1]  <= dd[j];
        ovf[j+1] <= ovf[j];
        sgn[j+1] <= sgn[j];
      end
    end
  end

  assign mag = ovf[QB] ? (QB+1)'(1) << QB : {1'b0, qq[QB]};
  assign quo = sgn[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

/* src/vertex_rotate_project_core.sv */
// Channel   Signals                                           Direction
// input     in_valid, in_stall, model_x/y/z, last_vertex      vertex beats in
// output    out_valid, out_stall, screen_x/y, rotated_depth,  result beats out
//           last_out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data         register writes
//
// One vertex beat is taken per cycle while in_stall is low. After reset and
// after every register write the 3x3 matrix is rebuilt by a serial sequencer;
// in_stall and cfg_ready hold off traffic meanwhile. The perspective divides
// run in a 19-stage pipelined divider, one quotient bit per stage after its
// magnitude and overflow stages. A stalled output freezes the whole pipeline,
// so no beat is lost or repeated.
module vertex_rotate_project_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] model_x,
  input  logic signed [15:0] model_y,
  input  logic signed [15:0] model_z,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic signed [15:0] rotated_depth,
  output logic               last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int PW  = vrp_pkg::PW;
  localparam int SW  = vrp_pkg::SW;
  localparam int RW  = vrp_pkg::RW;
  localparam int NSW = vrp_pkg::NSW;
  localparam int DSW = vrp_pkg::DSW;
  localparam int QW  = vrp_pkg::QW;
  localparam int LAT = vrp_pkg::DIV_LAT;

  vrp_pkg::vrp_cfg_t cfg;
  vrp_pkg::coef_t    coef [9];
  logic busy, en, rebuild;

  logic signed [15:0] vin [3];
  logic signed [PW-1:0] prod [9];
  logic v1, l1;
  logic signed [RW-1:0] rot [3];
  logic v2, l2;
  logic signed [SW-1:0] rsum [3];

  logic signed [31:0] zf, zfix;
  logic signed [NSW-1:0] nx, ny;
  logic signed [DSW-1:0] dx, dy;
  logic signed [15:0] zs3;
  logic v3, l3;

  logic        side_v [LAT];
  logic        side_l [LAT];
  logic signed [15:0] side_z [LAT];
  logic signed [QW-1:0] qx, qy;
  logic signed [QW:0] sx_sum, sy_sum;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = busy || !en;
  assign cfg_ready = !busy;
  assign rebuild   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_x       <= 9'd0;
      cfg.angle_y       <= 9'd15;
      cfg.angle_z       <= 9'd0;
      cfg.zoom          <= 10'd27;
      cfg.model_divisor <= 15'd256;
      cfg.focal_shift   <= 16'sd400;
      cfg.centre_x      <= 16'sd88;
      cfg.centre_y      <= 16'sd90;
    end else if (rebuild) begin
      case (cfg_index)
        vrp_pkg::REG_ANGLE_X:       cfg.angle_x       <= cfg_data[8:0];
        vrp_pkg::REG_ANGLE_Y:       cfg.angle_y       <= cfg_data[8:0];
        vrp_pkg::REG_ANGLE_Z:       cfg.angle_z       <= cfg_data[8:0];
        vrp_pkg::REG_ZOOM:          cfg.zoom          <= cfg_data[9:0];
        vrp_pkg::REG_MODEL_DIVISOR: cfg.model_divisor <= cfg_data[14:0];
        vrp_pkg::REG_FOCAL_SHIFT:   cfg.focal_shift   <= $signed(cfg_data);
        vrp_pkg::REG_CENTRE_X:      cfg.centre_x      <= $signed(cfg_data);
        vrp_pkg::REG_CENTRE_Y:      cfg.centre_y      <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  vrp_matrix u_matrix (
    .clk   (clk),
    .rst   (rst),
    .start (rebuild),
    .cfg   (cfg),
    .busy  (busy),
    .coef  (coef)
  );

  assign vin[0] = model_x;
  assign vin[1] = model_y;
  assign vin[2] = model_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = SW'(prod[3*r]) + SW'(prod[3*r+1]) + SW'(prod[3*r+2]);
    end
  end

  // Perspective operands: x gets the exact 3/5 factor as *3 here and *5 on
  // the denominator.
  assign zf   = 32'(rot[2]) + 32'(cfg.focal_shift);
  assign zfix = (zf == 32'sd0) ? 32'sd1 : zf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        side_v[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && !busy;
      v2 <= v1;
      v3 <= v2;
      side_v[0] <= v3;
      for (int k = 1; k < LAT; k++) begin
        side_v[k] <= side_v[k-1];
      end
      out_valid <= side_v[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[3*r+c] <= PW'(coef[3*r+c]) * PW'(vin[c]);
        end
      end
      l1 <= last_vertex;
      for (int r = 0; r < 3; r++) begin
        rot[r] <= rsum[r][SW-1:8];
      end
      l2 <= l1;
      nx  <= NSW'(RW'(rot[0]) + (RW'(rot[0]) <<< 1) + 33'sd0) * NSW'(cfg.focal_shift);
      ny  <= NSW'(rot[1]) * NSW'(cfg.focal_shift);
      dx  <= (DSW'(zfix) <<< 2) + DSW'(zfix);
      dy  <= DSW'(zfix);
      zs3 <= vrp_pkg::sat16(32'(rot[2]));
      l3  <= l2;
      side_l[0] <= l3;
      side_z[0] <= zs3;
      for (int k = 1; k < LAT; k++) begin
        side_l[k] <= side_l[k-1];
        side_z[k] <= side_z[k-1];
      end
      screen_x      <= vrp_pkg::sat16(32'(sx_sum));
      screen_y      <= vrp_pkg::sat16(32'(sy_sum));
      rotated_depth <= side_z[LAT-1];
      last_out      <= side_l[LAT-1];
    end
  end

  vrp_div_pipe u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx),
    .den (dx),
    .quo (qx)
  );

  vrp_div_pipe u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny),
    .den (dy),
    .quo (qy)
  );

  assign sx_sum = (QW+1)'(cfg.centre_x) + (QW+1)'(qx);
  assign sy_sum = (QW+1)'(cfg.centre_y) + (QW+1)'(qy);

endmodule
